// ===== rtl/dsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared sizes, action codes and the adjacency write request for the dense
// shortest-path engine.
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int WEIGHT_BITS  = 16;

  // Vertex index, vertex count (holds MAX_VERTICES itself) and matrix address
  localparam int IDX_W   = $clog2(MAX_VERTICES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int ADJ_AW  = 2 * IDX_W;
  localparam int ADJ_DEPTH = MAX_VERTICES * MAX_VERTICES;

  localparam int DIST_W = 20;
  localparam logic [DIST_W-1:0] DIST_CAP = {DIST_W{1'b1}};

  localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(MAX_VERTICES);

  localparam logic [1:0] ACT_EDGE  = 2'd0;
  localparam logic [1:0] ACT_RUN   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic                   we;
    logic                   clr;
    logic [ADJ_AW-1:0]      addr;
    logic [WEIGHT_BITS-1:0] data;
  } adj_wr_t;

endpackage
`default_nettype wire

// ===== rtl/dense_shortest_path_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dense_shortest_path_engine
// Single-source shortest paths over a stored undirected weighted matrix.
//
// Input channel (in_valid/in_ready) takes one action per transfer: an edge
// write (both symmetric entries, the second from ST_EDGE2), a clear of all
// edges, or a run. in_ready is high only while the controller is idle.
// A run alternates a select pass (stream the distance store, keep the
// unsettled reachable minimum) and a relax pass (stream the settled vertex's
// matrix row and the distance store, write back better distances), at most
// n rounds plus one final select; the registered read ports of the two
// memories set the per-vertex step. Results then leave on out_valid/out_ready,
// one per vertex in ascending order, with last on the final one. A stalled
// receiver holds the output register and the output pass waits on it; after
// the last result is loaded the block takes new items again.
// Reset (rst, synchronous) empties the matrix and sets vertex_count to 16.
// The user writes vertex_count through cfg_we/cfg_wdata only while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dense_shortest_path_engine (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [dsp_pkg::CNT_W-1:0]       cfg_wdata,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [1:0]                      action,
  input  wire  [dsp_pkg::IDX_W-1:0]       vertex_a,
  input  wire  [dsp_pkg::IDX_W-1:0]       vertex_b,
  input  wire  [15:0]                     edge_weight,
  input  wire  [dsp_pkg::IDX_W-1:0]       start_vertex,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [dsp_pkg::IDX_W-1:0]       target_vertex,
  output logic [dsp_pkg::DIST_W-1:0]      distance,
  output logic                            reachable,
  output logic                            last
);
  import dsp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE2,
    ST_SEL,
    ST_RLX,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

  state_t state;

  logic [CNT_W-1:0]        vcount;
  logic [CNT_W-1:0]        n_eff;
  logic [IDX_W-1:0]        last_idx;

  logic [IDX_W-1:0]        cnt;
  logic                    issue_on;
  logic                    p_vld;
  logic [IDX_W-1:0]        p_idx;

  logic                    best_found;
  logic [IDX_W-1:0]        best_idx;
  logic [DIST_W-1:0]       best_d;
  logic [IDX_W-1:0]        u_idx;
  logic [DIST_W-1:0]       u_d;

  logic [MAX_VERTICES-1:0] settled;
  logic [MAX_VERTICES-1:0] dvalid;

  logic [IDX_W-1:0]        ea;
  logic [IDX_W-1:0]        eb;
  logic [WEIGHT_BITS-1:0]  ew;

  adj_wr_t                 adj_wr;
  logic [WEIGHT_BITS-1:0]  adj_rd;
  logic [DIST_W-1:0]       dist_rd;
  logic                    dist_we;
  logic [IDX_W-1:0]        dist_waddr;
  logic [DIST_W-1:0]       dist_wdata;

  logic                    in_xfer;
  logic                    start_ok;
  logic                    sel_take;
  logic                    found_f;
  logic [IDX_W-1:0]        idx_f;
  logic [DIST_W-1:0]       d_f;
  logic [DIST_W:0]         sum;
  logic [DIST_W-1:0]       cand;
  logic                    relax_upd;
  logic                    pass_end;

  // Vertex count clamped to 1..MAX_VERTICES
  always_comb begin
    if (vcount == '0) begin
      n_eff = CNT_W'(1);
    end else if (vcount > VCOUNT_RESET) begin
      n_eff = VCOUNT_RESET;
    end else begin
      n_eff = vcount;
    end
  end
  assign last_idx = IDX_W'(n_eff - CNT_W'(1));

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign start_ok = ({1'b0, start_vertex} < n_eff);
  assign pass_end = p_vld && (p_idx == last_idx);

  // Select: running minimum over the streamed distances
  assign sel_take = p_vld && !settled[p_idx] && dvalid[p_idx] &&
                    (!best_found || (dist_rd < best_d));
  assign found_f  = best_found || sel_take;
  assign idx_f    = sel_take ? p_idx : best_idx;
  assign d_f      = sel_take ? dist_rd : best_d;

  // Relax: saturating path sum against the stored distance
  assign sum       = {1'b0, u_d} + (DIST_W+1)'(adj_rd);
  assign cand      = sum[DIST_W] ? DIST_CAP : sum[DIST_W-1:0];
  assign relax_upd = (state == ST_RLX) && p_vld && !settled[p_idx] &&
                     (adj_rd != '0) && (!dvalid[p_idx] || (cand < dist_rd));

  always_comb begin
    adj_wr.we   = 1'b0;
    adj_wr.clr  = 1'b0;
    adj_wr.addr = {vertex_a, vertex_b};
    adj_wr.data = edge_weight[WEIGHT_BITS-1:0];
    if (in_xfer && (action == ACT_EDGE)) begin
      adj_wr.we = 1'b1;
    end else if (in_xfer && (action == ACT_CLEAR)) begin
      adj_wr.clr = 1'b1;
    end else if (state == ST_EDGE2) begin
      adj_wr.we   = 1'b1;
      adj_wr.addr = {eb, ea};
      adj_wr.data = ew;
    end
  end

  assign dist_we    = (in_xfer && (action == ACT_RUN) && start_ok) || relax_upd;
  assign dist_waddr = (state == ST_RLX) ? p_idx : start_vertex;
  assign dist_wdata = (state == ST_RLX) ? cand : '0;

  dsp_adj_mem u_adj (
    .clk   (clk),
    .rst   (rst),
    .wr    (adj_wr),
    .raddr ({u_idx, cnt}),
    .rdata (adj_rd)
  );

  dsp_dist_mem u_dist (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (cnt),
    .rdata (dist_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= VCOUNT_RESET;
    end else if (cfg_we) begin
      vcount <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      cnt        <= '0;
      issue_on   <= 1'b0;
      p_vld      <= 1'b0;
      best_found <= 1'b0;
      settled    <= '0;
      dvalid     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            case (action)
              ACT_EDGE: begin
                ea    <= vertex_a;
                eb    <= vertex_b;
                ew    <= edge_weight[WEIGHT_BITS-1:0];
                state <= ST_EDGE2;
              end
              ACT_RUN: begin
                settled    <= '0;
                cnt        <= '0;
                issue_on   <= 1'b1;
                p_vld      <= 1'b0;
                best_found <= 1'b0;
                if (start_ok) begin
                  dvalid <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << start_vertex;
                  state  <= ST_SEL;
                end else begin
                  dvalid <= '0;
                  state  <= ST_OUT_RD;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end

        ST_EDGE2: begin
          state <= ST_IDLE;
        end

        ST_SEL, ST_RLX: begin
          // advance the read stream one vertex per cycle
          if (issue_on) begin
            p_vld <= 1'b1;
            p_idx <= cnt;
            if (cnt == last_idx) begin
              issue_on <= 1'b0;
            end else begin
              cnt <= cnt + IDX_W'(1);
            end
          end else begin
            p_vld <= 1'b0;
          end

          if (state == ST_SEL) begin
            if (sel_take) begin
              best_found <= 1'b1;
              best_idx   <= p_idx;
              best_d     <= dist_rd;
            end
          end else if (relax_upd) begin
            dvalid[p_idx] <= 1'b1;
          end

          if (pass_end) begin
            cnt        <= '0;
            issue_on   <= 1'b1;
            p_vld      <= 1'b0;
            best_found <= 1'b0;
            if (state == ST_RLX) begin
              state <= ST_SEL;
            end else if (found_f) begin
              settled[idx_f] <= 1'b1;
              u_idx          <= idx_f;
              u_d            <= d_f;
              state          <= ST_RLX;
            end else begin
              state <= ST_OUT_RD;
            end
          end
        end

        ST_OUT_RD: begin
          state <= ST_OUT_LD;
        end

        ST_OUT_LD: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            target_vertex <= cnt;
            distance      <= dvalid[cnt] ? dist_rd : '0;
            reachable     <= dvalid[cnt];
            last          <= (cnt == last_idx);
            if (cnt == last_idx) begin
              state <= ST_IDLE;
            end else begin
              cnt   <= cnt + IDX_W'(1);
              state <= ST_OUT_RD;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_settled_reached: assert property (@(posedge clk) disable iff (rst)
    (settled & ~dvalid) == '0)
    else $error("settled vertex without a finite distance");

  a_dist_write_phase: assert property (@(posedge clk) disable iff (rst)
    dist_we |-> (state == ST_IDLE || state == ST_RLX))
    else $error("distance store written outside init or relax");

  a_relax_source: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RLX) |-> (settled[u_idx] && dvalid[u_idx]))
    else $error("relax pass from an unsettled vertex");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !p_vld)
    else $error("read stream still busy while taking input");

endmodule
`default_nettype wire

// ===== rtl/dsp_adj_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_adj_mem
// Adjacency matrix: one write port, one registered read port. A valid bit
// per entry makes unwritten and cleared entries read as zero weight.
// ----------------------------------------------------------------------------
module dsp_adj_mem (
  input  wire                             clk,
  input  wire                             rst,
  input  dsp_pkg::adj_wr_t                wr,
  input  wire  [dsp_pkg::ADJ_AW-1:0]      raddr,
  output logic [dsp_pkg::WEIGHT_BITS-1:0] rdata
);
  import dsp_pkg::*;

  logic [WEIGHT_BITS-1:0] mem [ADJ_DEPTH];
  logic [ADJ_DEPTH-1:0]   vld;
  logic [WEIGHT_BITS-1:0] rd_q;
  logic                   rd_vld;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.clr) begin
        vld <= '0;
      end else if (wr.we) begin
        vld[wr.addr] <= 1'b1;
      end
      rd_vld <= vld[raddr];
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule
`default_nettype wire

// ===== rtl/dsp_dist_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_dist_mem
// Per-vertex distance store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dsp_dist_mem (
  input  wire                         clk,
  input  wire                         we,
  input  wire  [dsp_pkg::IDX_W-1:0]   waddr,
  input  wire  [dsp_pkg::DIST_W-1:0]  wdata,
  input  wire  [dsp_pkg::IDX_W-1:0]   raddr,
  output logic [dsp_pkg::DIST_W-1:0]  rdata
);
  import dsp_pkg::*;

  logic [DIST_W-1:0] mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
